FILE: rtl/assert_macros.svh
// Assertion helper macros for the trimmed mean filter.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TMSF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define TMSF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tmsf_pkg.sv
// Shared types and constants for the trimmed mean sample filter.
// No dependencies.
`timescale 1ns / 1ps

package tmsf_pkg;

    localparam int CHAN_W   = 3;
    localparam int SAMPLE_W = 12;
    localparam int SLOTS    = 1 << CHAN_W;

    localparam logic [SAMPLE_W-1:0] SAMPLE_FULL = {SAMPLE_W{1'b1}};

    typedef logic [CHAN_W-1:0]   t_chan;
    typedef logic [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        t_sample max_val;
        t_sample min_val;
    } t_ext;

endpackage

FILE: rtl/trimmed_mean_sample_filter.sv
// Top level of the trimmed mean sample filter: front end, window queue,
// back end. Depends on tmsf_pkg, tmsf_front, tmsf_queue, tmsf_back.
//
//   channel  direction  signals                       fields
//   input    in         i_valid / o_stall             i_channel, i_sample
//   output   out        o_valid / i_stall             o_out_channel, o_average
//
// One sample per cycle while o_stall is low; per-channel state is updated in the accepting cycle.
// A completed window passes the window queue, then the back end's trim, multiply, quotient and output registers.
// o_stall is high while the four-entry window queue is full.
// A stalled output holds the back end's trim/divide pipeline in place.
// Reset clears all channel windows at once; no clearing pass.
`timescale 1ns / 1ps

module trimmed_mean_sample_filter #(
    parameter int SAMPLES  = 10,
    parameter int CHANNELS = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  tmsf_pkg::t_chan   i_channel,
    input  tmsf_pkg::t_sample i_sample,
    output logic             o_valid,
    input  logic             i_stall,
    output tmsf_pkg::t_chan   o_out_channel,
    output tmsf_pkg::t_sample o_average
);
    import tmsf_pkg::*;

    localparam int SW = $clog2(SAMPLES * 4095 + 1);

    logic          push;
    t_chan         push_chan;
    logic [SW-1:0] push_sum;
    t_ext          push_ext;
    logic          q_full;
    logic          q_not_empty;
    logic          q_pop;
    t_chan         q_chan;
    logic [SW-1:0] q_sum;
    t_ext          q_ext;

    tmsf_front #(
        .SAMPLES  (SAMPLES),
        .CHANNELS (CHANNELS),
        .SW       (SW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_full      (q_full),
        .i_channel   (i_channel),
        .i_sample    (i_sample),
        .o_push      (push),
        .o_push_chan (push_chan),
        .o_push_sum  (push_sum),
        .o_push_ext  (push_ext)
    );

    tmsf_queue #(
        .SW (SW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_chan      (push_chan),
        .i_sum       (push_sum),
        .i_ext       (push_ext),
        .i_pop       (q_pop),
        .o_full      (q_full),
        .o_not_empty (q_not_empty),
        .o_chan      (q_chan),
        .o_sum       (q_sum),
        .o_ext       (q_ext)
    );

    tmsf_back #(
        .SAMPLES (SAMPLES),
        .SW      (SW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_avail       (q_not_empty),
        .i_chan        (q_chan),
        .i_sum         (q_sum),
        .i_ext         (q_ext),
        .o_pop         (q_pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_channel (o_out_channel),
        .o_average     (o_average)
    );

    assign o_stall = q_full;

`include "assert_macros.svh"

    `TMSF_ASSERT(a_no_push_when_full, !(push && q_full), "push into full queue")
    `TMSF_ASSERT_IMP(a_pop_needs_data, q_pop, q_not_empty, "pop from empty queue")
    `TMSF_ASSERT_IMP(a_out_chan_range, o_valid, int'(o_out_channel) < CHANNELS,
        "result for channel out of range")

endmodule

FILE: rtl/tmsf_front.sv
// Front end: accepts samples, keeps per-channel window state,
// and pushes completed windows. Depends on tmsf_pkg.
`timescale 1ns / 1ps

module tmsf_front #(
    parameter int SAMPLES  = 10,
    parameter int CHANNELS = 7,
    parameter int SW       = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_full,
    input  tmsf_pkg::t_chan   i_channel,
    input  tmsf_pkg::t_sample i_sample,
    output logic             o_push,
    output tmsf_pkg::t_chan   o_push_chan,
    output logic [SW-1:0]    o_push_sum,
    output tmsf_pkg::t_ext    o_push_ext
);
    import tmsf_pkg::*;

    localparam int CW = $clog2(SAMPLES + 1);

    logic [SW-1:0] r_sum [SLOTS];
    t_sample       r_max [SLOTS];
    t_sample       r_min [SLOTS];
    logic [CW-1:0] r_cnt [SLOTS];

    logic          hit;
    logic          done;
    logic [SW-1:0] n_sum;
    t_sample       n_max;
    t_sample       n_min;
    logic [CW-1:0] n_cnt;

    always_comb begin
        hit   = i_valid && !i_full && (int'(i_channel) < CHANNELS);
        n_sum = r_sum[i_channel] + SW'(i_sample);
        n_max = (i_sample > r_max[i_channel]) ? i_sample : r_max[i_channel];
        n_min = (i_sample < r_min[i_channel]) ? i_sample : r_min[i_channel];
        n_cnt = r_cnt[i_channel] + CW'(1);
        done  = (n_cnt == CW'(SAMPLES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                r_sum[s] <= '0;
                r_max[s] <= '0;
                r_min[s] <= SAMPLE_FULL;
                r_cnt[s] <= '0;
            end
        end else if (hit) begin
            if (done) begin
                r_sum[i_channel] <= '0;
                r_max[i_channel] <= '0;
                r_min[i_channel] <= SAMPLE_FULL;
                r_cnt[i_channel] <= '0;
            end else begin
                r_sum[i_channel] <= n_sum;
                r_max[i_channel] <= n_max;
                r_min[i_channel] <= n_min;
                r_cnt[i_channel] <= n_cnt;
            end
        end
    end

    assign o_push             = hit && done;
    assign o_push_chan        = i_channel;
    assign o_push_sum         = n_sum;
    assign o_push_ext.max_val = n_max;
    assign o_push_ext.min_val = n_min;

endmodule

FILE: rtl/tmsf_queue.sv
// Four-entry queue of completed windows between front and back end.
// Depends on tmsf_pkg.
`timescale 1ns / 1ps

module tmsf_queue #(
    parameter int SW = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tmsf_pkg::t_chan   i_chan,
    input  logic [SW-1:0]    i_sum,
    input  tmsf_pkg::t_ext    i_ext,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_not_empty,
    output tmsf_pkg::t_chan   o_chan,
    output logic [SW-1:0]    o_sum,
    output tmsf_pkg::t_ext    o_ext
);
    import tmsf_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    t_chan         r_chan [DEPTH];
    logic [SW-1:0] r_sum  [DEPTH];
    t_ext          r_ext  [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_count;
    logic [PW:0]   n_count;
    logic          do_pop;

    always_comb begin
        do_pop  = i_pop && (r_count != '0);
        n_count = r_count + (PW+1)'(i_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_chan[r_wr] <= i_chan;
            r_sum[r_wr]  <= i_sum;
            r_ext[r_wr]  <= i_ext;
        end
    end

    assign o_full      = (r_count == (PW+1)'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_chan      = r_chan[r_rd];
    assign o_sum       = r_sum[r_rd];
    assign o_ext       = r_ext[r_rd];

endmodule

FILE: rtl/tmsf_back.sv
// Back end: trims extremes and divides by SAMPLES-2 through a
// reciprocal multiply with one correction step. Depends on tmsf_pkg.
`timescale 1ns / 1ps

module tmsf_back #(
    parameter int SAMPLES = 10,
    parameter int SW      = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_avail,
    input  tmsf_pkg::t_chan   i_chan,
    input  logic [SW-1:0]    i_sum,
    input  tmsf_pkg::t_ext    i_ext,
    output logic             o_pop,
    input  logic             i_stall,
    output logic             o_valid,
    output tmsf_pkg::t_chan   o_out_channel,
    output tmsf_pkg::t_sample o_average
);
    import tmsf_pkg::*;

    localparam int            DIV   = SAMPLES - 2;
    localparam logic [SW-1:0] DIV_W = SW'(DIV);
    localparam logic [SW:0]   RECIP = (SW+1)'((64'(1) << SW) / DIV);

    logic          en;

    logic          r_v1, r_v2, r_v3;
    t_chan         r_ch1, r_ch2, r_ch3;
    logic [SW-1:0] r_t1, r_t2, r_t3;
    logic [2*SW:0] r_prod;
    t_sample       r_q0;
    logic [SW-1:0] r_qd;

    t_sample       q0;
    logic [SW-1:0] rem;
    t_sample       n_avg;

    logic          r_out_valid;
    t_chan         r_out_chan;
    t_sample       r_out_avg;

    always_comb begin
        en    = !r_out_valid || !i_stall;
        o_pop = en && i_avail;
        q0    = r_prod[SW+SAMPLE_W-1:SW];
        rem   = r_t3 - r_qd;
        n_avg = (rem >= DIV_W) ? r_q0 + SAMPLE_W'(1) : r_q0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v1        <= i_avail;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_out_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ch1      <= i_chan;
            r_t1       <= i_sum - SW'(i_ext.max_val) - SW'(i_ext.min_val);
            r_ch2      <= r_ch1;
            r_t2       <= r_t1;
            r_prod     <= (2*SW+1)'(r_t1) * (2*SW+1)'(RECIP);
            r_ch3      <= r_ch2;
            r_t3       <= r_t2;
            r_q0       <= q0;
            r_qd       <= SW'(SW'(q0) * DIV_W);
            r_out_chan <= r_ch3;
            r_out_avg  <= n_avg;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_channel = r_out_chan;
    assign o_average     = r_out_avg;

endmodule
